// ===== rtl/kei_pkg.sv =====
// shared types, constants and helpers for the keyframe ease interpolator
package kei_pkg;

  localparam int unsigned DefMaxKeyframes = 16;
  localparam int unsigned EntryW = 176;
  localparam int unsigned ElapsedW = 34;

  localparam logic [1:0] CFG_START_TIME  = 2'd0;
  localparam logic [1:0] CFG_BASE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_BASE_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_KEY_COUNT   = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [3:0]         entry_index;
    logic [15:0]        key_duration;
    logic signed [23:0] key_pos_x;
    logic signed [23:0] key_pos_y;
    logic [15:0]        key_scale_x;
    logic [15:0]        key_scale_y;
    logic [31:0]        key_color;
    logic signed [15:0] key_rotation;
    logic signed [15:0] ease_y1;
    logic signed [15:0] ease_y2;
    logic [31:0]        time_now;
  } kei_req_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [23:0]        width_out;
    logic [23:0]        height_out;
    logic [31:0]        color_out;
    logic signed [15:0] rotation_out;
    logic [3:0]         segment_index;
  } kei_rsp_t;

  typedef struct packed {
    logic [15:0]        dur;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [31:0]        rgba;
    logic signed [15:0] rot;
    logic signed [15:0] y1;
    logic signed [15:0] y2;
  } kei_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_DIV, ST_RDA, ST_RDB, ST_E1, ST_E2, ST_E3, ST_E4,
    ST_MIX, ST_SCL, ST_OUT
  } kei_state_e;

  function automatic logic signed [41:0] kei_mix(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [23:0] e);
    logic signed [32:0] d;
    logic signed [56:0] pr;
    d  = 33'(b) - 33'(a);
    pr = 57'(d) * 57'(e);
    return 42'(a) + 42'(pr >>> 16);
  endfunction

  function automatic logic signed [41:0] kei_clamp(input logic signed [41:0] v,
                                                   input logic signed [41:0] lo,
                                                   input logic signed [41:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

endpackage

// ===== rtl/kei_div.sv =====
// restoring divider for the segment phase, one quotient bit per cycle
module kei_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  logic [15:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [16:0] trial;

  always_comb begin
    trial  = {rem_q, 1'b0};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i;
      cnt_d = 5'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 16'(trial - {1'b0, den_q});
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than a cycle");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("divider done without a run");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> cnt_q < 5'd16) else $error("divider count overran");
endmodule

// ===== rtl/keyframe_ease_interpolator.sv =====
// top level: keyframe store, segment walk and eased interpolation
// a load request writes the store and leaves busy_o low; an evaluate request keeps busy_o high
// while it walks the segments over the single store read port (a read and a check step per
// segment), runs the phase divider once the active segment is found (skipped past the last
// keyframe), then does two entry reads, four easing steps and a mix, scale and output step.
// the result is shown for one cycle on done_o and is not held off by the receiver.
module keyframe_ease_interpolator #(
  parameter int unsigned MAX_KEYFRAMES = kei_pkg::DefMaxKeyframes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  kei_pkg::kei_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output logic              done_o,
  output kei_pkg::kei_rsp_t result_o
);
  import kei_pkg::*;

  localparam int unsigned IW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYFRAMES + 1);

  kei_state_e state_q, state_d;

  logic [31:0] start_time_q;
  logic [11:0] base_w_q, base_h_q;
  logic [4:0]  count_q;

  logic [EntryW-1:0] mem_q [MAX_KEYFRAMES];
  logic [EntryW-1:0] rdata_q;
  logic [IW-1:0]     raddr;
  kei_entry_t        rd_ent, wr_ent, a_q, b_q;

  logic [31:0]         now_q;
  logic [ElapsedW-1:0] elapsed_q, elapsed_sum;
  logic [NW-1:0]       i_q, n_q, n_new;
  logic [IW-1:0]       prev_q, next_q;
  logic [16:0]         p_q;
  logic [15:0]         div_num;
  logic                div_start, div_done;
  logic [15:0]         div_quo;
  logic                accept, eval_ok, walk_hit;

  logic [33:0] uu_q, up_q, pp_q;
  logic [16:0] ca_q, cb_q, cc_q;
  logic signed [33:0] ta_q, tb_q;
  logic signed [23:0] e_q;
  logic signed [36:0] acc;

  logic signed [41:0] mx_px_q, mx_py_q, mx_rot_q;
  logic signed [26:0] mx_sx_q, mx_sy_q;
  logic signed [41:0] mx_col_q [4];
  logic signed [39:0] wprod, hprod;
  kei_rsp_t res_q;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign eval_ok = (req_i.mode == MODE_EVAL) && (req_i.time_now >= start_time_q);
  assign rd_ent  = kei_entry_t'(rdata_q);
  assign elapsed_sum = elapsed_q + ElapsedW'(rd_ent.dur);
  assign walk_hit = {2'b00, now_q} < elapsed_sum;
  assign div_num  = 16'({2'b00, now_q} - elapsed_q);

  always_comb begin
    if (count_q == 5'd0) n_new = NW'(1);
    else if (32'(count_q) > MAX_KEYFRAMES) n_new = NW'(MAX_KEYFRAMES);
    else n_new = NW'(count_q);
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= 32'd0;
      base_w_q     <= 12'd0;
      base_h_q     <= 12'd0;
      count_q      <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_TIME:  start_time_q <= cfg_data_i;
        CFG_BASE_WIDTH:  base_w_q     <= cfg_data_i[11:0];
        CFG_BASE_HEIGHT: base_h_q     <= cfg_data_i[11:0];
        CFG_KEY_COUNT:   count_q      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // keyframe store
  always_comb begin
    wr_ent.dur  = req_i.key_duration;
    wr_ent.px   = req_i.key_pos_x;
    wr_ent.py   = req_i.key_pos_y;
    wr_ent.sx   = req_i.key_scale_x;
    wr_ent.sy   = req_i.key_scale_y;
    wr_ent.rgba = req_i.key_color;
    wr_ent.rot  = req_i.key_rotation;
    wr_ent.y1   = req_i.ease_y1;
    wr_ent.y2   = req_i.ease_y2;
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.mode == MODE_LOAD && 32'(req_i.entry_index) < MAX_KEYFRAMES) begin
      mem_q[IW'(req_i.entry_index)] <= EntryW'(wr_ent);
    end
    rdata_q <= mem_q[raddr];
  end

  kei_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (rd_ent.dur),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && eval_ok) state_d = (n_new <= NW'(1)) ? ST_RDA : ST_RD;
      end
      ST_RD:  state_d = ST_CHK;
      ST_CHK: begin
        if (walk_hit) state_d = ST_DIV;
        else if (i_q + NW'(1) >= n_q) state_d = ST_RDA;
        else state_d = ST_RD;
      end
      ST_DIV: if (div_done) state_d = ST_RDA;
      ST_RDA: state_d = ST_RDB;
      ST_RDB: state_d = ST_E1;
      ST_E1:  state_d = ST_E2;
      ST_E2:  state_d = ST_E3;
      ST_E3:  state_d = ST_E4;
      ST_E4:  state_d = ST_MIX;
      ST_MIX: state_d = ST_SCL;
      ST_SCL: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr     = prev_q;
    div_start = 1'b0;
    case (state_q)
      ST_RD:   raddr = IW'(i_q - NW'(1));
      ST_CHK:  div_start = walk_hit;
      ST_RDA:  raddr = prev_q;
      ST_RDB:  raddr = next_q;
      default: raddr = prev_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // walk, easing, mixing and scaling datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        now_q     <= req_i.time_now;
        elapsed_q <= ElapsedW'(start_time_q);
        prev_q    <= '0;
        next_q    <= '0;
        i_q       <= NW'(1);
        n_q       <= n_new;
        p_q       <= 17'h10000;
      end
      ST_CHK: begin
        elapsed_q <= elapsed_sum;
        if (walk_hit) begin
          next_q <= IW'(i_q);
        end else begin
          prev_q <= IW'(i_q);
          next_q <= IW'(i_q);
          i_q    <= i_q + NW'(1);
        end
      end
      ST_DIV: if (div_done) p_q <= {1'b0, div_quo};
      ST_RDB: a_q <= rd_ent;
      ST_E1: begin
        b_q  <= rd_ent;
        uu_q <= 34'(17'h10000 - p_q) * 34'(17'h10000 - p_q);
        up_q <= 34'(17'h10000 - p_q) * 34'(p_q);
        pp_q <= 34'(p_q) * 34'(p_q);
      end
      ST_E2: begin
        ca_q <= 17'((51'(uu_q) * 51'(p_q)) >> 32);
        cb_q <= 17'((51'(up_q) * 51'(p_q)) >> 32);
        cc_q <= 17'((51'(pp_q) * 51'(p_q)) >> 32);
      end
      ST_E3: begin
        ta_q <= 34'($signed({1'b0, ca_q})) * 34'(b_q.y1);
        tb_q <= 34'($signed({1'b0, cb_q})) * 34'(b_q.y2);
      end
      ST_E4: e_q <= 24'(acc >>> 14);
      ST_MIX: begin
        mx_px_q  <= kei_mix(32'(a_q.px), 32'(b_q.px), e_q);
        mx_py_q  <= kei_mix(32'(a_q.py), 32'(b_q.py), e_q);
        mx_sx_q  <= 27'(kei_mix($signed({16'd0, a_q.sx}), $signed({16'd0, b_q.sx}), e_q));
        mx_sy_q  <= 27'(kei_mix($signed({16'd0, a_q.sy}), $signed({16'd0, b_q.sy}), e_q));
        mx_rot_q <= kei_mix(32'(a_q.rot), 32'(b_q.rot), e_q);
        for (int k = 0; k < 4; k++) begin
          mx_col_q[k] <= kei_mix($signed({24'd0, a_q.rgba[8*k +: 8]}),
                                 $signed({24'd0, b_q.rgba[8*k +: 8]}), e_q);
        end
      end
      ST_SCL: begin
        res_q.pos_x  <= 24'(kei_clamp(mx_px_q, -42'sd8388608, 42'sd8388607));
        res_q.pos_y  <= 24'(kei_clamp(mx_py_q, -42'sd8388608, 42'sd8388607));
        res_q.width_out  <= 24'(kei_clamp(42'(wprod), 42'sd0, 42'sd16777215));
        res_q.height_out <= 24'(kei_clamp(42'(hprod), 42'sd0, 42'sd16777215));
        for (int k = 0; k < 4; k++) begin
          res_q.color_out[8*k +: 8] <= 8'(kei_clamp(mx_col_q[k], 42'sd0, 42'sd255));
        end
        res_q.rotation_out  <= 16'(kei_clamp(mx_rot_q, -42'sd32768, 42'sd32767));
        res_q.segment_index <= 4'(prev_q);
      end
      default: ;
    endcase
  end

  assign acc = 37'sd3 * 37'(ta_q) + 37'sd3 * 37'(tb_q) + 37'($signed({1'b0, cc_q, 14'd0}));
  assign wprod = 40'(mx_sx_q) * 40'($signed({1'b0, base_w_q}));
  assign hprod = 40'(mx_sy_q) * 40'($signed({1'b0, base_h_q}));

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_OUT);
  assign result_o = res_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than a cycle");
  a_done_after_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_SCL)) else $error("result without scaling step");
  a_div_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("divider finished outside phase step");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (i_q < n_q)) else $error("walk beyond keyframes in use");
endmodule
